// ===== rtl/gsbf_pkg.sv =====
package gsbf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_FIRST = 5'd0;
  localparam logic [POS_W-1:0] POS_DATA  = 5'd15;
  localparam logic [POS_W-1:0] POS_LAST  = 5'd23;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [15:0] len;
    logic [15:0] taken;
    logic [31:0] crc;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] stream_byte(input job_t j, input logic [POS_W-1:0] pos);
    logic [15:0] inv;
    logic [7:0]  b;
    inv = ~j.len;
    case (pos)
      5'd0:    b = 8'h1F;
      5'd1:    b = 8'h8B;
      5'd2:    b = 8'h08;
      5'd8:    b = 8'h02;
      5'd9:    b = 8'hFF;
      5'd10:   b = 8'h01;
      5'd11:   b = j.len[7:0];
      5'd12:   b = j.len[15:8];
      5'd13:   b = inv[7:0];
      5'd14:   b = inv[15:8];
      5'd15:   b = j.data;
      5'd16:   b = j.crc[7:0];
      5'd17:   b = j.crc[15:8];
      5'd18:   b = j.crc[23:16];
      5'd19:   b = j.crc[31:24];
      5'd20:   b = j.taken[7:0];
      5'd21:   b = j.taken[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/gzip_stored_block_framer.sv =====
// Wraps a stream of payload bytes into gzip members, each holding one
// final stored deflate block of cfg-set length (1 to 65535 bytes).
// in_*: payload bytes, one request per byte. out_*: the gzip stream, one
// byte per request; out_tlast marks the last byte caused by an input byte
// and out_tuser marks the final footer byte of a member.
// cfg_*: writes the frame length; the user must write it only while the
// block is idle, which the block does not enforce. A byte is held in one
// job register and played out through a registered output stage. Mid-frame,
// payload streams at one byte per cycle while out_tready is high. The first
// byte of a frame is preceded by 15 header bytes and the last byte is
// followed by 8 footer bytes, which a sequence counter steps through. The
// next byte is accepted in the cycle the current job sends its final result.
// When out_tready is low the output register holds and the job waits behind
// it. Reset presets the running CRC, clears the byte count, sets the frame
// length to one and empties both stages.
module gzip_stored_block_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // run_last
  output logic [0:0]  out_tuser,  // [0] member_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] frame_length
);
  import gsbf_pkg::*;

  logic [15:0]      frame_len_r;
  logic [31:0]      crc_r, crc_nxt;
  logic [15:0]      count_r, count_nxt;
  logic             job_valid_r, job_valid_nxt;
  job_t             job_r, job_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_end_r;

  logic [15:0]      eff_len;
  logic [16:0]      taken;
  logic [31:0]      crc_upd;
  logic             in_acc;
  logic             out_load;
  logic [POS_W-1:0] job_end;
  logic             job_done;

  assign cfg_ready  = 1'b1;
  assign eff_len    = (frame_len_r == 16'd0) ? 16'd1 : frame_len_r;
  assign taken      = {1'b0, count_r} + 17'd1;
  assign crc_upd    = crc_byte(crc_r, in_tdata);

  assign out_load   = !out_valid_r || out_tready;
  assign job_end    = job_r.last ? POS_LAST : POS_DATA;
  assign job_done   = job_valid_r && out_load && (pos_r == job_end);
  assign in_tready  = !job_valid_r || job_done;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    crc_nxt       = crc_r;
    count_nxt     = count_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    pos_nxt       = pos_r;
    if (job_valid_r && out_load) begin
      pos_nxt = pos_r + 5'd1;
      if (pos_r == job_end) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      job_valid_nxt = 1'b1;
      job_nxt.first = (count_r == 16'd0);
      job_nxt.last  = (taken >= {1'b0, eff_len});
      job_nxt.data  = in_tdata;
      job_nxt.len   = eff_len;
      job_nxt.taken = taken[15:0];
      job_nxt.crc   = ~crc_upd;
      pos_nxt       = (count_r == 16'd0) ? POS_FIRST : POS_DATA;
      if (taken >= {1'b0, eff_len}) begin
        crc_nxt   = CRC_INIT;
        count_nxt = 16'd0;
      end else begin
        crc_nxt   = crc_upd;
        count_nxt = taken[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= 16'd1;
      crc_r       <= CRC_INIT;
      count_r     <= 16'd0;
      job_valid_r <= 1'b0;
      pos_r       <= POS_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_len_r <= cfg_data;
      end
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      job_valid_r <= job_valid_nxt;
      pos_r       <= pos_nxt;
      if (out_load) begin
        out_valid_r <= job_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (out_load && job_valid_r) begin
      out_byte_r <= stream_byte(job_r, pos_r);
      out_last_r <= (pos_r == job_end);
      out_end_r  <= job_r.last && (pos_r == POS_LAST);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_end_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_last_r)
    else $error("member end without run end");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (pos_r <= job_end) && (job_r.first || pos_r >= POS_DATA))
    else $error("sequence position out of range");

  a_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && job_valid_r |-> out_load && (pos_r == job_end))
    else $error("input accepted while job still running");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (taken < {1'b0, eff_len}) |=> (count_r != 16'd0))
    else $error("byte count lost mid-frame");

endmodule
